/* rtl/bmp_pixel_unpacker_assert.svh */
// Assertion macros for the BMP pixel unpacker.
`ifndef BMP_PIXEL_UNPACKER_ASSERT_SVH
`define BMP_PIXEL_UNPACKER_ASSERT_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge outside reset.
`define BMPPU_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bmp_pixel_unpacker: assertion failed");

// Implication that must hold at every clock edge outside reset.
`define BMPPU_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bmp_pixel_unpacker: implication failed");

`else

`define BMPPU_ASSERT(name, prop)
`define BMPPU_ASSERT_IMP(name, ante, cons)

`endif

`endif

/* rtl/bmppu_pkg.sv */
// Shared types and constants of the BMP pixel unpacker.
`timescale 1ns / 1ps

package bmppu_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 4096;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  localparam int unsigned DEST_W  = 26;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned CH_W    = 3;
  localparam int unsigned QDEPTH  = 2;

  // Header byte offsets.
  localparam int unsigned DS_OFF      = 10;
  localparam int unsigned WIDTH_OFF   = 18;
  localparam int unsigned HEIGHT_OFF  = 22;
  localparam int unsigned DEPTH_OFF   = 28;
  localparam int unsigned COMP_OFF    = 30;
  localparam int unsigned HDR_END_OFF = 33;
  localparam int unsigned PIX_MIN_OFF = 34;

  localparam int unsigned DEPTH_24 = 24;
  localparam int unsigned DEPTH_32 = 32;

  typedef enum logic [2:0] {
    KIND_HDR_OK     = 3'd0,
    KIND_PIXEL      = 3'd1,
    KIND_COMPRESSED = 3'd2,
    KIND_BAD_DEPTH  = 3'd3,
    KIND_TOO_LARGE  = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [DEST_W-1:0]  row_base;
    logic [DEST_W-1:0]  col;
    logic [1:0]         cp;
    logic [7:0]         value;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [CH_W-1:0]    ch;
    logic               last;
  } entry_t;

endpackage

/* rtl/bmppu_front.sv */
// Front end: byte offset tracking, header capture and checks, pixel walk.
`timescale 1ns / 1ps

module bmppu_front #(
  parameter int unsigned MAX_WIDTH  = bmppu_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = bmppu_pkg::MAX_HEIGHT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         file_byte_i,
  input  logic               frame_start_i,
  output logic               push_o,
  output bmppu_pkg::entry_t  push_data_o,
  input  logic               q_full_i
);
  import bmppu_pkg::*;

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW = WW + 2;
  localparam int unsigned CW = RW + 1;
  localparam int unsigned PW = HW + RW;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_PIXEL  = 3'b010,
    PH_DONE   = 3'b100
  } phase_e;

  function automatic logic [31:0] put_byte(input logic [31:0] word, input logic [1:0] pos,
                                           input logic [7:0] b);
    logic [31:0] r;
    r = word;
    r[8*pos +: 8] = b;
    return r;
  endfunction

  logic              accept;
  logic [31:0]       off_q, off_d, off_eff, off_inc;
  phase_e            phase_q, phase_d, phase_eff;
  logic [31:0]       ds_q, width_q, height_q;
  logic [15:0]       depth_q;
  logic [23:0]       comp_q;
  logic [RW-1:0]     rw_q, rw_calc;
  logic [DEST_W-1:0] mul_q;
  logic [31:0]       start_q;
  logic [CW-1:0]     rp_q;
  logic [HW-1:0]     hlast_q;
  logic [HW-1:0]     row_q, row_d;
  logic [CW-1:0]     col_q, col_d, col_nx, rw_ext, rw_p3;
  logic [1:0]        cp_q, cp_d;
  logic [DEST_W-1:0] base_q, base_d;
  logic [31:0]       h_abs;
  logic [WW-1:0]     w_lo;
  logic [HW-1:0]     h_lo, hm1;
  logic [PW-1:0]     prod;
  logic              ch4, at_hdr_end, comp_nz, depth_ok, too_big, empty_img;
  logic              off_ok, pix_emit, pix_last;
  kind_e             hdr_kind;
  entry_t            entry;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;

  // A frame start restarts the parse at this byte.
  assign off_eff   = frame_start_i ? '0 : off_q;
  assign phase_eff = frame_start_i ? PH_HEADER : phase_q;
  assign off_inc   = (off_eff == '1) ? off_eff : off_eff + 32'd1;

  assign h_abs   = height_q[31] ? (~height_q + 32'd1) : height_q;
  assign w_lo    = width_q[WW-1:0];
  assign h_lo    = h_abs[HW-1:0];
  assign hm1     = h_lo - HW'(1);
  assign ch4     = (depth_q == 16'(DEPTH_32));
  assign rw_calc = ch4 ? {w_lo, 2'b00} : ({1'b0, w_lo, 1'b0} + {2'b00, w_lo});
  assign prod    = PW'(hm1) * PW'(rw_q);
  assign rw_ext  = {1'b0, rw_q};
  assign rw_p3   = rw_ext + CW'(3);

  assign at_hdr_end = (phase_eff == PH_HEADER) && (off_eff == HDR_END_OFF);
  assign comp_nz    = ({file_byte_i, comp_q} != 32'd0);
  assign depth_ok   = (depth_q == 16'(DEPTH_24)) || (depth_q == 16'(DEPTH_32));
  assign too_big    = (width_q > 32'(MAX_WIDTH)) || (h_abs > 32'(MAX_HEIGHT));
  assign empty_img  = (width_q == 32'd0) || (h_abs == 32'd0);

  always_comb begin
    if (comp_nz)        hdr_kind = KIND_COMPRESSED;
    else if (!depth_ok) hdr_kind = KIND_BAD_DEPTH;
    else if (too_big)   hdr_kind = KIND_TOO_LARGE;
    else                hdr_kind = KIND_HDR_OK;
  end

  assign off_ok   = (off_eff >= start_q);
  assign pix_emit = off_ok && (col_q < rw_ext);
  assign pix_last = (row_q == hlast_q) && (col_q == rw_ext - CW'(1));
  assign col_nx   = col_q + CW'(1);

  always_comb begin
    off_d   = off_q;
    phase_d = phase_q;
    row_d   = row_q;
    col_d   = col_q;
    cp_d    = cp_q;
    base_d  = base_q;
    push_o  = 1'b0;
    entry   = '0;
    if (accept) begin
      off_d   = off_inc;
      phase_d = phase_eff;
      case (phase_eff)
        PH_HEADER: begin
          if (at_hdr_end) begin
            push_o     = 1'b1;
            entry.kind = hdr_kind;
            if (hdr_kind != KIND_HDR_OK) begin
              phase_d = PH_DONE;
            end else begin
              entry.width  = width_q[DIM_W-1:0];
              entry.height = h_abs[DIM_W-1:0];
              entry.ch     = ch4 ? CH_W'(4) : CH_W'(3);
              row_d = '0;
              col_d = '0;
              cp_d  = '0;
              base_d = height_q[31] ? '0 : mul_q;
              if (empty_img) begin
                base_d  = '0;
                phase_d = PH_DONE;
              end else begin
                phase_d = PH_PIXEL;
              end
            end
          end
        end
        PH_PIXEL: begin
          if (off_ok) begin
            if (pix_emit) begin
              push_o         = 1'b1;
              entry.kind     = KIND_PIXEL;
              entry.row_base = base_q;
              entry.col      = DEST_W'(col_q);
              entry.cp       = cp_q;
              entry.value    = file_byte_i;
              entry.width    = width_q[DIM_W-1:0];
              entry.height   = h_abs[DIM_W-1:0];
              entry.ch       = ch4 ? CH_W'(4) : CH_W'(3);
              entry.last     = pix_last;
              cp_d = (cp_q == (ch4 ? 2'd3 : 2'd2)) ? 2'd0 : cp_q + 2'd1;
            end
            col_d = col_nx;
            if (pix_emit && pix_last) begin
              phase_d = PH_DONE;
            end else if (col_nx >= rp_q) begin
              // Row done including padding: advance to the next raster row.
              col_d  = '0;
              cp_d   = '0;
              row_d  = row_q + HW'(1);
              base_d = height_q[31] ? base_q + DEST_W'(rw_q) : base_q - DEST_W'(rw_q);
            end
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign push_data_o = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q   <= '0;
      phase_q <= PH_HEADER;
      row_q   <= '0;
      col_q   <= '0;
      cp_q    <= '0;
      base_q  <= '0;
    end else begin
      off_q   <= off_d;
      phase_q <= phase_d;
      row_q   <= row_d;
      col_q   <= col_d;
      cp_q    <= cp_d;
      base_q  <= base_d;
    end
  end

  // Header fields, and row geometry precomputed while the header streams in.
  always_ff @(posedge clk_i) begin
    if (accept && phase_eff == PH_HEADER) begin
      if (off_eff >= DS_OFF && off_eff <= DS_OFF + 3)
        ds_q <= put_byte(ds_q, 2'(off_eff - DS_OFF), file_byte_i);
      else if (off_eff >= WIDTH_OFF && off_eff <= WIDTH_OFF + 3)
        width_q <= put_byte(width_q, 2'(off_eff - WIDTH_OFF), file_byte_i);
      else if (off_eff >= HEIGHT_OFF && off_eff <= HEIGHT_OFF + 3)
        height_q <= put_byte(height_q, 2'(off_eff - HEIGHT_OFF), file_byte_i);
      else if (off_eff >= DEPTH_OFF && off_eff <= DEPTH_OFF + 1)
        depth_q <= 16'(put_byte({16'd0, depth_q}, 2'(off_eff - DEPTH_OFF), file_byte_i));
      else if (off_eff >= COMP_OFF && off_eff <= COMP_OFF + 2)
        comp_q <= 24'(put_byte({8'd0, comp_q}, 2'(off_eff - COMP_OFF), file_byte_i));
    end
    if (accept && at_hdr_end) begin
      start_q <= (ds_q < PIX_MIN_OFF) ? 32'(PIX_MIN_OFF) : ds_q;
      rp_q    <= {rw_p3[CW-1:2], 2'b00};
      hlast_q <= hm1;
    end
    rw_q  <= rw_calc;
    mul_q <= DEST_W'(prod);
  end

endmodule

/* rtl/bmppu_fifo.sv */
// Short queue between the parse front end and the output back end.
`timescale 1ns / 1ps

module bmppu_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bmppu_pkg::entry_t  push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output bmppu_pkg::entry_t  data_o
);
  import bmppu_pkg::*;

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  entry_t             mem_q [QDEPTH];
  logic [PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) wr_d = (wr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    if (pop_i)  rd_d = (rd_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    if (push_i && !pop_i)      cnt_d = cnt_q + CNT_W'(1);
    else if (!push_i && pop_i) cnt_d = cnt_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

endmodule

/* rtl/bmppu_back.sv */
// Back end: raster index with channel swap, and the output register.
`timescale 1ns / 1ps

module bmppu_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               q_valid_i,
  input  bmppu_pkg::entry_t                  q_data_i,
  output logic                               q_pop_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [2:0]                         result_kind_o,
  output logic [bmppu_pkg::DEST_W-1:0]       dest_index_o,
  output logic [7:0]                         pixel_value_o,
  output logic [bmppu_pkg::DIM_W-1:0]        raster_width_o,
  output logic [bmppu_pkg::DIM_W-1:0]        raster_height_o,
  output logic [bmppu_pkg::CH_W-1:0]         channels_o,
  output logic                               last_pixel_o
);
  import bmppu_pkg::*;

  logic              take;
  logic              valid_q, valid_d;
  logic [DEST_W-1:0] adj, dest;
  kind_e             kind_q;
  logic [DEST_W-1:0] dest_q;
  logic [7:0]        value_q;
  logic [DIM_W-1:0]  width_q, height_q;
  logic [CH_W-1:0]   ch_q;
  logic              last_q;

  assign take    = q_valid_i && (!valid_q || !out_stall_i);
  assign q_pop_o = take;

  // Swap channels 0 and 2 within the pixel.
  always_comb begin
    case (q_data_i.cp)
      2'd0:    adj = DEST_W'(2);
      2'd2:    adj = '1 - DEST_W'(1);
      default: adj = '0;
    endcase
  end

  assign dest = (q_data_i.kind == KIND_PIXEL) ? q_data_i.row_base + q_data_i.col + adj : '0;

  always_comb begin
    valid_d = valid_q;
    if (take)              valid_d = 1'b1;
    else if (!out_stall_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q   <= q_data_i.kind;
      dest_q   <= dest;
      value_q  <= q_data_i.value;
      width_q  <= q_data_i.width;
      height_q <= q_data_i.height;
      ch_q     <= q_data_i.ch;
      last_q   <= q_data_i.last;
    end
  end

  assign out_valid_o     = valid_q;
  assign result_kind_o   = kind_q;
  assign dest_index_o    = dest_q;
  assign pixel_value_o   = value_q;
  assign raster_width_o  = width_q;
  assign raster_height_o = height_q;
  assign channels_o      = ch_q;
  assign last_pixel_o    = last_q;

endmodule

/* rtl/bmp_pixel_unpacker.sv */
// Top level of the BMP pixel unpacker.
//
// Input channel (in_valid_i / in_stall_o): one byte of a BMP file per
// transaction, in file order; frame_start_i marks the first byte of a file.
// Output channel (out_valid_o / out_stall_i): one transaction per header
// verdict (ok with width, height and channel count, or an error code) and
// one per pixel byte, carrying its index in a top-down, unpadded RGB/RGBA
// raster with red and blue swapped. Padding and trailing bytes give nothing.
// Throughput: one byte per clock cycle while the queue is not full; the
// parse state (offset, row, column and channel counters) updates once per
// byte and the bottom-up row start is multiplied out while the header
// streams in. The edge that accepts a byte writes its result into the
// two-entry queue, and the output register loads it from there when it is
// empty or the receiver does not stall.
// Reset clears the offset, the parse phase, the counters and the queue.
// When the receiver stalls, the output holds and the queue fills; the input
// stalls only once the queue is full.
`timescale 1ns / 1ps

`include "bmp_pixel_unpacker_assert.svh"

module bmp_pixel_unpacker #(
  parameter int unsigned MAX_WIDTH  = bmppu_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = bmppu_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    file_byte_i,
  input  logic                          frame_start_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    result_kind_o,
  output logic [bmppu_pkg::DEST_W-1:0]  dest_index_o,
  output logic [7:0]                    pixel_value_o,
  output logic [bmppu_pkg::DIM_W-1:0]   raster_width_o,
  output logic [bmppu_pkg::DIM_W-1:0]   raster_height_o,
  output logic [bmppu_pkg::CH_W-1:0]    channels_o,
  output logic                          last_pixel_o
);
  import bmppu_pkg::*;

  logic   q_push, q_full, q_pop, q_valid;
  entry_t q_wdata, q_rdata;
  logic   out_is_err, err_fields_zero;

  bmppu_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .file_byte_i   (file_byte_i),
    .frame_start_i (frame_start_i),
    .push_o        (q_push),
    .push_data_o   (q_wdata),
    .q_full_i      (q_full)
  );

  bmppu_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_rdata)
  );

  bmppu_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_data_i        (q_rdata),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_kind_o   (result_kind_o),
    .dest_index_o    (dest_index_o),
    .pixel_value_o   (pixel_value_o),
    .raster_width_o  (raster_width_o),
    .raster_height_o (raster_height_o),
    .channels_o      (channels_o),
    .last_pixel_o    (last_pixel_o)
  );

  assign out_is_err = out_valid_o && (result_kind_o == KIND_COMPRESSED ||
                                      result_kind_o == KIND_BAD_DEPTH ||
                                      result_kind_o == KIND_TOO_LARGE);
  assign err_fields_zero = (dest_index_o == '0) && (raster_width_o == '0) &&
                           (raster_height_o == '0) && (channels_o == '0);

  `BMPPU_ASSERT(a_queue_no_overflow, !(q_push && q_full))
  `BMPPU_ASSERT_IMP(a_last_only_on_pixel, out_valid_o && last_pixel_o, result_kind_o == KIND_PIXEL)
  `BMPPU_ASSERT_IMP(a_error_fields_zero, out_is_err, err_fields_zero)

endmodule

/* verif/tb.sv */
// Self-checking testbench for the BMP pixel unpacker.
`timescale 1ns / 1ps

module tb;
  import bmppu_pkg::*;

  localparam int unsigned FULL_FILE  = 1_000_000;
  localparam int unsigned HDR_ONLY   = 36;
  localparam int unsigned RAND_BYTES = 300;
  localparam int unsigned HOLD_LEN   = 300;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PIXEL,
    PH_DONE
  } parse_phase_e;

  typedef struct {
    kind_e             kind;
    logic [DEST_W-1:0] dest;
    logic [7:0]        value;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [CH_W-1:0]   ch;
    logic              last;
  } raster_result_t;

  class bmp_unpack_scoreboard;
    raster_result_t unpacked_due[$];
    int unsigned    errors;
    int unsigned    headers_seen;
    int unsigned    pixels_seen;

    logic [31:0]  offset;
    logic [31:0]  data_start;
    logic [31:0]  width_w;
    logic [31:0]  height_w;
    logic [15:0]  depth_w;
    logic [31:0]  compress_w;
    parse_phase_e phase;
    logic [31:0]  row_cnt;
    logic [31:0]  col;
    logic [1:0]   chan;
    logic [63:0]  row_start;

    function void clear();
      offset     = '0;
      data_start = '0;
      width_w    = '0;
      height_w   = '0;
      depth_w    = '0;
      compress_w = '0;
      phase      = PH_HEADER;
      row_cnt    = '0;
      col        = '0;
      chan       = '0;
      row_start  = '0;
    endfunction

    function logic [31:0] abs_height();
      return height_w[31] ? ~height_w + 32'd1 : height_w;
    endfunction

    function void queue_result(kind_e k, logic [DEST_W-1:0] dest, logic [7:0] v,
                               logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                               logic [CH_W-1:0] ch, logic last);
      raster_result_t r;
      r.kind   = k;
      r.dest   = dest;
      r.value  = v;
      r.width  = w;
      r.height = h;
      r.ch     = ch;
      r.last   = last;
      unpacked_due.push_back(r);
    endfunction

    // Work out what one accepted file byte produces.
    function void unpack_byte(logic [7:0] fb, logic fs);
      logic [31:0] off;
      logic [31:0] h;
      logic [31:0] rw;
      logic [31:0] rp;
      logic [31:0] start;
      logic [31:0] dc;
      logic [2:0]  ch;
      logic [63:0] dest;
      logic        last_b;
      kind_e       k;
      if (fs) clear();
      off = offset;
      if (offset != 32'hFFFF_FFFF) offset++;

      if (phase == PH_HEADER) begin
        if (off >= DS_OFF && off <= DS_OFF + 3) begin
          data_start[8*(off-DS_OFF) +: 8] = fb;
        end else if (off >= WIDTH_OFF && off <= WIDTH_OFF + 3) begin
          width_w[8*(off-WIDTH_OFF) +: 8] = fb;
        end else if (off >= HEIGHT_OFF && off <= HEIGHT_OFF + 3) begin
          height_w[8*(off-HEIGHT_OFF) +: 8] = fb;
        end else if (off >= DEPTH_OFF && off <= DEPTH_OFF + 1) begin
          depth_w[8*(off-DEPTH_OFF) +: 8] = fb;
        end else if (off >= COMP_OFF && off <= COMP_OFF + 3) begin
          compress_w[8*(off-COMP_OFF) +: 8] = fb;
        end
        if (off != HDR_END_OFF) return;
        h = abs_height();
        // Compression wins over depth, depth over size.
        if (compress_w != 0) k = KIND_COMPRESSED;
        else if (depth_w != DEPTH_24 && depth_w != DEPTH_32) k = KIND_BAD_DEPTH;
        else if (width_w > MAX_WIDTH_DEF || h > MAX_HEIGHT_DEF) k = KIND_TOO_LARGE;
        else k = KIND_HDR_OK;
        if (k != KIND_HDR_OK) begin
          queue_result(k, '0, '0, '0, '0, '0, 1'b0);
          phase = PH_DONE;
          return;
        end
        ch = (depth_w == DEPTH_32) ? 3'd4 : 3'd3;
        queue_result(KIND_HDR_OK, '0, '0, width_w[DIM_W-1:0], h[DIM_W-1:0], ch, 1'b0);
        rw      = width_w * ch;
        row_cnt = '0;
        col     = '0;
        chan    = '0;
        row_start = height_w[31] ? 64'd0 : 64'(h - 32'd1) * 64'(rw);
        if (width_w == 0 || h == 0) begin
          row_start = '0;
          phase     = PH_DONE;
        end else begin
          phase = PH_PIXEL;
        end
        return;
      end

      if (phase == PH_PIXEL) begin
        ch     = (depth_w == DEPTH_32) ? 3'd4 : 3'd3;
        h      = abs_height();
        rw     = width_w * ch;
        rp     = (rw + 32'd3) & ~32'd3;
        start  = (data_start < PIX_MIN_OFF) ? PIX_MIN_OFF : data_start;
        last_b = 1'b0;
        if (off < start) return;
        if (col < rw) begin
          // Swap red and blue within the pixel.
          dc     = (chan == 0) ? 32'd2 : ((chan == 2) ? 32'd0 : 32'(chan));
          dest   = row_start + 64'(col - 32'(chan)) + 64'(dc);
          last_b = (row_cnt == h - 32'd1) && (col == rw - 32'd1);
          queue_result(KIND_PIXEL, dest[DEST_W-1:0], fb, width_w[DIM_W-1:0],
                       h[DIM_W-1:0], ch, last_b);
          chan = (32'(chan) + 32'd1 >= 32'(ch)) ? 2'd0 : chan + 2'd1;
        end
        col++;
        if (last_b) begin
          phase = PH_DONE;
        end else if (col >= rp) begin
          col  = '0;
          chan = '0;
          row_cnt++;
          if (height_w[31]) row_start += 64'(rw);
          else row_start -= 64'(rw);
        end
      end
    endfunction

    function void cmp_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
    endfunction

    function void match_result(logic [2:0] kind, logic [DEST_W-1:0] dest, logic [7:0] value,
                               logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                               logic [CH_W-1:0] ch, logic last);
      raster_result_t want;
      if (unpacked_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, kind %0d dest %0d value %0d", $time, kind, dest,
                 value);
        return;
      end
      want = unpacked_due.pop_front();
      if (want.kind == KIND_PIXEL) pixels_seen++;
      else headers_seen++;
      cmp_field("result_kind", want.kind, kind);
      cmp_field("dest_index", want.dest, dest);
      cmp_field("pixel_value", want.value, value);
      cmp_field("raster_width", want.width, w);
      cmp_field("raster_height", want.height, h);
      cmp_field("channels", want.ch, ch);
      cmp_field("last_pixel", want.last, last);
    endfunction
  endclass

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic [7:0]        file_byte_i   = 8'd0;
  logic              frame_start_i = 1'b0;
  logic              out_stall_i   = 1'b0;
  logic              in_stall_o;
  logic              out_valid_o;
  logic [2:0]        result_kind_o;
  logic [DEST_W-1:0] dest_index_o;
  logic [7:0]        pixel_value_o;
  logic [DIM_W-1:0]  raster_width_o;
  logic [DIM_W-1:0]  raster_height_o;
  logic [CH_W-1:0]   channels_o;
  logic              last_pixel_o;

  bmp_unpack_scoreboard sb;
  bit          tx_idle;
  bit          rx_idle;
  bit          hold_req;
  int unsigned bytes_sent;
  int unsigned files_sent;

  always #10 clk_i = ~clk_i;

  bmp_pixel_unpacker u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .file_byte_i     (file_byte_i),
    .frame_start_i   (frame_start_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_kind_o   (result_kind_o),
    .dest_index_o    (dest_index_o),
    .pixel_value_o   (pixel_value_o),
    .raster_width_o  (raster_width_o),
    .raster_height_o (raster_height_o),
    .channels_o      (channels_o),
    .last_pixel_o    (last_pixel_o)
  );

  // Offer one byte and hold it until the transaction completes.
  task automatic push_byte(input logic [7:0] fb, input logic fs);
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    file_byte_i   <= fb;
    frame_start_i <= fs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.unpack_byte(fb, fs);
    @(negedge clk_i);
  endtask

  // Build a BMP file with random filler and pixel data, then stream it.
  task automatic send_file(input logic [31:0] w, input logic [31:0] hgt,
                           input int unsigned depth, input logic [31:0] comp,
                           input logic [31:0] doff, input int unsigned max_len,
                           input int unsigned trail, input bit fs_first);
    logic [7:0]      img[$];
    logic [8*34-1:0] hdr;
    logic [31:0]     habs;
    longint unsigned rp;
    longint unsigned body;
    int unsigned     ch;
    for (int i = 0; i < 34; i++) hdr[8*i +: 8] = 8'($urandom_range(0, 255));
    hdr[8*DS_OFF +: 32]     = doff;
    hdr[8*WIDTH_OFF +: 32]  = w;
    hdr[8*HEIGHT_OFF +: 32] = hgt;
    hdr[8*DEPTH_OFF +: 16]  = 16'(depth);
    hdr[8*COMP_OFF +: 32]   = comp;
    for (int i = 0; i < 34; i++) img.push_back(hdr[8*i +: 8]);
    ch   = (depth == DEPTH_32) ? 4 : 3;
    habs = hgt[31] ? ~hgt + 32'd1 : hgt;
    rp   = (64'(w) * ch + 64'd3) & ~64'd3;
    if (comp == 0 && (depth == DEPTH_24 || depth == DEPTH_32) && w <= MAX_WIDTH_DEF &&
        habs <= MAX_HEIGHT_DEF) body = rp * 64'(habs);
    else body = 8;
    for (longint unsigned k = 34; k < 64'(doff) && img.size() < max_len; k++)
      img.push_back(8'($urandom_range(0, 255)));
    for (longint unsigned k = 0; k < body && img.size() < max_len; k++)
      img.push_back(8'($urandom_range(0, 255)));
    while (img.size() > max_len) void'(img.pop_back());
    bytes_sent += img.size();
    repeat (trail) img.push_back(8'($urandom_range(0, 255)));
    files_sent++;
    foreach (img[i]) push_byte(img[i], (i == 0) ? fs_first : 1'b0);
  endtask

  task automatic send_noise(input int unsigned n);
    bytes_sent += n;
    for (int unsigned i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)), i == 0);
  endtask

  // Receiver: random stall bursts, plus one long hold on request.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_LEN) @(negedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (rx_idle && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.match_result(result_kind_o, dest_index_o, pixel_value_o, raster_width_o,
                      raster_height_o, channels_o, last_pixel_o);
    end
  end

  initial begin
    #5_000_000;
    $display("tb failed");
    $finish;
  end

  initial begin
    logic [31:0] w;
    logic [31:0] hgt;
    logic [31:0] comp;
    logic [31:0] doff;
    int unsigned depth;
    int unsigned sel;
    int unsigned h;
    int unsigned rand_start;
    int unsigned drain;
    sb = new();
    sb.clear();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Well-formed images; the first one relies on reset alone.
    send_file(2, 2, DEPTH_24, 0, 54, FULL_FILE, 4, 1'b0);
    send_file(3, 32'hFFFF_FFFE, DEPTH_32, 0, 0, FULL_FILE, 3, 1'b1);
    send_file(1, 1, DEPTH_24, 0, 34, FULL_FILE, 2, 1'b1);
    send_file(5, 32'hFFFF_FFFD, DEPTH_24, 0, 40, FULL_FILE, 0, 1'b1);
    send_file(7, 32'hFFFF_FFFF, DEPTH_32, 0, 34, FULL_FILE, 0, 1'b1);
    // Header errors, including compression with a bad depth.
    send_file(2, 2, 16, 1, 54, HDR_ONLY, 4, 1'b1);
    send_file(2, 2, DEPTH_24, 32'h8000_0000, 54, HDR_ONLY, 0, 1'b1);
    send_file(2, 2, 16, 0, 54, HDR_ONLY, 0, 1'b1);
    send_file(2, 2, 32'h0000_0118, 0, 54, HDR_ONLY, 0, 1'b1);
    send_file(2, 2, 0, 0, 54, HDR_ONLY, 0, 1'b1);
    send_file(4097, 2, DEPTH_24, 0, 54, HDR_ONLY, 0, 1'b1);
    send_file(32'hFFFF_FFFF, 2, DEPTH_24, 0, 54, HDR_ONLY, 0, 1'b1);
    send_file(2, 4097, DEPTH_32, 0, 54, HDR_ONLY, 0, 1'b1);
    send_file(2, 32'hFFFF_EFFF, DEPTH_32, 0, 54, HDR_ONLY, 0, 1'b1);
    // Empty images: ok header, no pixels, trailing bytes ignored.
    send_file(0, 3, DEPTH_24, 0, 54, 40, 6, 1'b1);
    send_file(3, 0, DEPTH_32, 0, 54, 40, 6, 1'b1);
    // Largest geometry, cut short after a few pixel bytes.
    send_file(4096, 32'hFFFF_F000, DEPTH_32, 0, 54, 74, 0, 1'b1);
    send_file(4096, 4096, DEPTH_32, 0, 34, 60, 0, 1'b1);
    // Restart in the middle of a header, then data offset out of reach.
    send_file(3, 3, DEPTH_24, 0, 54, 20, 0, 1'b1);
    send_file(3, 3, DEPTH_24, 0, 32'hFFFF_0000, 80, 0, 1'b1);
    // Hold off the receiver so the queue fills and the input stalls.
    hold_req = 1'b1;
    send_file(4, 4, DEPTH_32, 0, 54, FULL_FILE, 0, 1'b1);
    send_noise(20);

    rand_start = bytes_sent;
    while (bytes_sent - rand_start < RAND_BYTES) begin
      if (bytes_sent - rand_start > RAND_BYTES - 200) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end else begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end
      sel   = $urandom_range(0, 99);
      w     = $urandom_range(1, 6);
      h     = $urandom_range(1, 4);
      hgt   = $urandom_range(0, 1) ? 32'd0 - h : h;
      depth = $urandom_range(0, 1) ? DEPTH_32 : DEPTH_24;
      comp  = 0;
      case ($urandom_range(0, 3))
        0: doff = $urandom_range(0, 33);
        1: doff = PIX_MIN_OFF;
        2: doff = 54;
        default: doff = $urandom_range(35, 70);
      endcase
      if (sel < 65) begin
        send_file(w, hgt, depth, comp, doff, FULL_FILE, $urandom_range(0, 5), 1'b1);
      end else if (sel < 77) begin
        send_file(w, hgt, depth, comp, doff, $urandom_range(10, 80), 0, 1'b1);
      end else if (sel < 87) begin
        case ($urandom_range(0, 3))
          0: begin
            comp = $urandom;
            if (comp == 0) comp = 1;
          end
          1: depth = $urandom_range(0, 65535);
          2: w = $urandom_range(0, 1) ? $urandom_range(4097, 70000) : $urandom;
          default: hgt = $urandom_range(0, 1) ? 32'd4097 + $urandom_range(0, 9999)
                                              : 32'hFFFF_EFFF - $urandom_range(0, 9999);
        endcase
        send_file(w, hgt, depth, comp, doff, FULL_FILE, $urandom_range(0, 5), 1'b1);
      end else if (sel < 92) begin
        if ($urandom_range(0, 1)) w = 0;
        else hgt = 0;
        send_file(w, hgt, depth, comp, doff, FULL_FILE, $urandom_range(0, 5), 1'b1);
      end else begin
        send_noise($urandom_range(5, 60));
      end
    end
    in_valid_i <= 1'b0;

    drain = 0;
    while (sb.unpacked_due.size() != 0 && drain < 20000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (10) @(posedge clk_i);
    if (sb.unpacked_due.size() != 0) begin
      sb.errors += sb.unpacked_due.size();
      $display("%0t: %0d expected results never arrived", $time, sb.unpacked_due.size());
    end
    $display("Streamed %0d files (%0d non-trailing bytes) with random stalls on both sides",
             files_sent, bytes_sent);
    $display("Checked %0d header verdicts and %0d pixel bytes, %0d mismatches",
             sb.headers_seen, sb.pixels_seen, sb.errors);
    if (sb.errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end
endmodule

/* bmp_pixel_unpacker.f */
+incdir+rtl
rtl/bmppu_pkg.sv
rtl/bmppu_front.sv
rtl/bmppu_fifo.sv
rtl/bmppu_back.sv
rtl/bmp_pixel_unpacker.sv
verif/tb.sv
